// ----- design/cpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the cascaded prescaled timer bank.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int DATA_W     = 16;
    localparam int CTL_W      = 8;
    localparam int PSC_W      = 10;
    localparam int FLAG_W     = 4;
    localparam int MAX_TIMERS = 8;

    // Transaction function codes
    localparam logic [1:0] FUNC_TICK      = 2'd0;
    localparam logic [1:0] FUNC_WR_RELOAD = 2'd1;
    localparam logic [1:0] FUNC_WR_CTRL   = 2'd2;
    localparam logic [1:0] FUNC_RD_COUNT  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FIFO_A_SEL = 1'b0;
    localparam logic CFG_FIFO_B_SEL = 1'b1;

    // Control byte bits
    localparam int CTL_RUN_BIT     = 7;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_CASCADE_BIT = 2;

    // Command from the bank to one timer cell, already qualified by acceptance
    typedef struct packed {
        logic              tick;
        logic              wr_reload;
        logic              wr_ctrl;
        logic [DATA_W-1:0] data;
    } t_cell_cmd;

    function automatic logic [PSC_W-1:0] prescale_mask(input logic [1:0] sel);
        logic [PSC_W-1:0] m;
        case (sel)
            2'd0:    m = 10'h000;
            2'd1:    m = 10'h03F;
            2'd2:    m = 10'h0FF;
            default: m = 10'h3FF;
        endcase
        return m;
    endfunction

endpackage

// ----- design/cpt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_cell
// One timer: counter, reload value and control byte. Takes the overflow of
// the previous cell as its cascade input and hands its own overflow on.
// ----------------------------------------------------------------------------
module cpt_cell #(
    parameter int COUNT_WIDTH = 16,
    parameter bit IS_FIRST    = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cpt_pkg::t_cell_cmd        i_cmd,
    input  logic [cpt_pkg::PSC_W-1:0] i_prescale_count,
    input  logic                      i_carry,
    output logic                      o_carry,
    output logic                      o_irq,
    output logic [cpt_pkg::DATA_W-1:0] o_count_lo
);
    import cpt_pkg::*;

    localparam int LO_W = (COUNT_WIDTH < DATA_W) ? COUNT_WIDTH : DATA_W;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic [CTL_W-1:0]       r_ctl, n_ctl;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   cascade;
    logic                   counts;
    logic                   wraps;

    assign cascade   = r_ctl[CTL_CASCADE_BIT] && !IS_FIRST;
    assign counts    = r_ctl[CTL_RUN_BIT] &&
                       (cascade ? i_carry
                                : ((i_prescale_count & prescale_mask(r_ctl[1:0])) == '0));
    assign count_inc = r_count + COUNT_WIDTH'(1);
    assign wraps     = (count_inc == '0);

    assign o_carry    = i_cmd.tick && counts && wraps;
    assign o_irq      = o_carry && r_ctl[CTL_IRQ_BIT];
    assign o_count_lo = DATA_W'(r_count[LO_W-1:0]);

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_ctl    = r_ctl;
        if (i_cmd.tick && counts) begin
            n_count = wraps ? r_reload : count_inc;
        end
        if (i_cmd.wr_reload) begin
            n_reload = COUNT_WIDTH'(i_cmd.data[LO_W-1:0]);
        end
        if (i_cmd.wr_ctrl) begin
            n_ctl = i_cmd.data[CTL_W-1:0];
            // load only on a rising edge of run
            if (i_cmd.data[CTL_RUN_BIT] && !r_ctl[CTL_RUN_BIT]) begin
                n_count = r_reload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_ctl    <= '0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_ctl    <= n_ctl;
        end
    end

endmodule

// ----- design/cascaded_prescaled_timers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_prescaled_timers
// Bank of cascadable up-counters paced by a shared 10-bit prescale count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction: a tick, a
//   reload write, a control byte write or a counter read for one timer.
//   Every transaction yields exactly one result on the output channel
//   (o_valid / i_ready): the read count and the per-tick overflow, interrupt
//   and sound FIFO request flags.
//   o_valid rises in the cycle after acceptance. One transaction is taken
//   every cycle while the receiver keeps up; the tick path is the overflow
//   carry rippling through the timer cells at once, so NUM_TIMERS sets logic depth.
//   The result sits in an output register; while it waits, o_ready stays
//   high only if the receiver takes it in the same cycle, so a stalled
//   receiver holds off the sender with no result lost.
//   The FIFO timer selects are written through i_cfg_we / i_cfg_index /
//   i_cfg_data, by the user only while the bank is idle (not enforced).
//   Reset (synchronous, active low) clears all counts, reloads, control
//   bytes, the prescale count and both selects, and empties the output;
//   o_ready stays low while reset is held.
// ----------------------------------------------------------------------------
module cascaded_prescaled_timers #(
    parameter int NUM_TIMERS  = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic                        i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_func,
    input  logic [1:0]                  i_timer_index,
    input  logic [cpt_pkg::DATA_W-1:0]  i_write_data,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cpt_pkg::DATA_W-1:0]  o_read_data,
    output logic [cpt_pkg::FLAG_W-1:0]  o_overflow_flags,
    output logic [cpt_pkg::FLAG_W-1:0]  o_irq_flags,
    output logic                        o_fifo_a_request,
    output logic                        o_fifo_b_request
);
    import cpt_pkg::*;

    logic                   accept;
    logic                   r_valid;
    logic                   r_sel_a;
    logic                   r_sel_b;
    logic [PSC_W-1:0]       r_psc;
    logic [DATA_W-1:0]      r_read_data, n_read_data;
    logic [FLAG_W-1:0]      r_ovf, r_irq;
    logic                   r_fa, r_fb;

    logic [NUM_TIMERS:0]    carry;
    logic [MAX_TIMERS-1:0]  ovf_all;
    logic [MAX_TIMERS-1:0]  irq_all;
    logic [DATA_W-1:0]      count_lo [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  addressed;
    t_cell_cmd              cmd [NUM_TIMERS];
    logic                   n_fa, n_fb;

    assign o_ready = i_rst_n && (!r_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign carry[0] = 1'b0;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        assign addressed[g]     = ({1'b0, i_timer_index} == 3'(g));
        assign cmd[g].tick      = accept && (i_func == FUNC_TICK);
        assign cmd[g].wr_reload = accept && (i_func == FUNC_WR_RELOAD) && addressed[g];
        assign cmd[g].wr_ctrl   = accept && (i_func == FUNC_WR_CTRL) && addressed[g];
        assign cmd[g].data      = i_write_data;

        cpt_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .IS_FIRST    (g == 0)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_cmd            (cmd[g]),
            .i_prescale_count (r_psc),
            .i_carry          (carry[g]),
            .o_carry          (carry[g+1]),
            .o_irq            (irq_all[g]),
            .o_count_lo       (count_lo[g])
        );
        assign ovf_all[g] = carry[g+1];
    end

    for (genvar g = NUM_TIMERS; g < MAX_TIMERS; g++) begin : g_pad
        assign ovf_all[g] = 1'b0;
        assign irq_all[g] = 1'b0;
    end

    // pick the addressed count on a read
    always_comb begin
        n_read_data = '0;
        if (i_func == FUNC_RD_COUNT) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                if (addressed[k]) begin
                    n_read_data = count_lo[k];
                end
            end
        end
    end

    assign n_fa = r_sel_a ? ovf_all[1] : ovf_all[0];
    assign n_fb = r_sel_b ? ovf_all[1] : ovf_all[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel_a <= 1'b0;
            r_sel_b <= 1'b0;
            r_psc   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIFO_A_SEL: r_sel_a <= i_cfg_data;
                    CFG_FIFO_B_SEL: r_sel_b <= i_cfg_data;
                    default:        r_sel_a <= r_sel_a;
                endcase
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            // advance the cycle count on ticks only
            if (accept && (i_func == FUNC_TICK)) begin
                r_psc <= r_psc + PSC_W'(1);
            end
        end
    end

    // hold the payload until a new transaction replaces it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_ovf       <= ovf_all[FLAG_W-1:0];
            r_irq       <= irq_all[FLAG_W-1:0];
            r_fa        <= n_fa;
            r_fb        <= n_fb;
        end
    end

    assign o_valid          = r_valid;
    assign o_read_data      = r_read_data;
    assign o_overflow_flags = r_ovf;
    assign o_irq_flags      = r_irq;
    assign o_fifo_a_request = r_fa;
    assign o_fifo_b_request = r_fb;

endmodule

// ----- tb/tb_cascaded_prescaled_timers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascaded_prescaled_timers
// Self-checking bench for the timer bank. A short table of directed
// transactions runs first, then random ones under four FIFO select settings.
// Both channels stall at random. Every result is checked against a model of the
// bank inside the bench, or for a typed table row against that row's value.
// ----------------------------------------------------------------------------
module tb_cascaded_prescaled_timers;
    import cpt_pkg::*;

    localparam int NTIM        = 4;
    localparam int PHASE_LEN   = 380;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [FLAG_W-1:0] ovf;
        logic [FLAG_W-1:0] irq;
        logic              fifo_a;
        logic              fifo_b;
    } t_timer_result;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        idx;
        logic [DATA_W-1:0] data;
        logic              typed;
        t_timer_result     want;
    } t_timer_txn;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_index   = CFG_FIFO_A_SEL;
    logic              i_cfg_data    = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [1:0]        i_func        = FUNC_TICK;
    logic [1:0]        i_timer_index = 2'd0;
    logic [DATA_W-1:0] i_write_data  = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic [FLAG_W-1:0] o_overflow_flags;
    logic [FLAG_W-1:0] o_irq_flags;
    logic              o_fifo_a_request;
    logic              o_fifo_b_request;

    cascaded_prescaled_timers dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_timer_index    (i_timer_index),
        .i_write_data     (i_write_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_data      (o_read_data),
        .o_overflow_flags (o_overflow_flags),
        .o_irq_flags      (o_irq_flags),
        .o_fifo_a_request (o_fifo_a_request),
        .o_fifo_b_request (o_fifo_b_request)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bank model state, in step with the block
    logic [DATA_W-1:0] bank_count  [NTIM] = '{default: '0};
    logic [DATA_W-1:0] bank_reload [NTIM] = '{default: '0};
    logic [CTL_W-1:0]  bank_ctrl   [NTIM] = '{default: '0};
    logic [PSC_W-1:0]  bank_cycle  = '0;
    logic              fifo_a_sel  = 1'b0;
    logic              fifo_b_sel  = 1'b0;

    t_timer_result expect_q [$];
    t_timer_txn    directed_rows [$];

    // Per-transaction hints travelling with the payload
    logic          offer_typed = 1'b0;
    t_timer_result offer_want  = '0;

    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;

    // Apply one transaction to the bank model and return its result
    function automatic t_timer_result step_timer_bank(input logic [1:0] func,
            input logic [1:0] idx, input logic [DATA_W-1:0] data);
        t_timer_result    r;
        logic             carry;
        logic             fires;
        logic [CTL_W-1:0] ctl;
        logic [PSC_W-1:0] div_mask;
        r = '0;
        if (func == FUNC_TICK) begin
            carry = 1'b0;
            for (int i = 0; i < NTIM; i++) begin
                ctl = bank_ctrl[i];
                case (ctl[1:0])
                    2'd0: begin
                        div_mask = 10'h000;
                    end
                    2'd1: begin
                        div_mask = 10'h03F;
                    end
                    2'd2: begin
                        div_mask = 10'h0FF;
                    end
                    default: begin
                        div_mask = 10'h3FF;
                    end
                endcase
                if (!ctl[CTL_RUN_BIT]) begin
                    fires = 1'b0;
                end else if (i != 0 && ctl[CTL_CASCADE_BIT]) begin
                    fires = carry;
                end else begin
                    fires = (bank_cycle & div_mask) == '0;
                end
                // carry only reaches the next timer in the row
                carry = 1'b0;
                if (fires) begin
                    bank_count[i] = bank_count[i] + 1'b1;
                    if (bank_count[i] == '0) begin
                        bank_count[i] = bank_reload[i];
                        carry    = 1'b1;
                        r.ovf[i] = 1'b1;
                        r.irq[i] = ctl[CTL_IRQ_BIT];
                        if (i == int'(fifo_a_sel)) begin
                            r.fifo_a = 1'b1;
                        end
                        if (i == int'(fifo_b_sel)) begin
                            r.fifo_b = 1'b1;
                        end
                    end
                end
            end
            bank_cycle = bank_cycle + 1'b1;
        end else if (func == FUNC_WR_RELOAD) begin
            bank_reload[idx] = data;
        end else if (func == FUNC_WR_CTRL) begin
            // load only on a rising edge of the run bit
            if (data[CTL_RUN_BIT] && !bank_ctrl[idx][CTL_RUN_BIT]) begin
                bank_count[idx] = bank_reload[idx];
            end
            bank_ctrl[idx] = data[CTL_W-1:0];
        end else begin
            r.read_data = bank_count[idx];
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] func, input logic [1:0] idx,
            input logic [DATA_W-1:0] data, input logic typed, input t_timer_result want);
        t_timer_txn t;
        t.func  = func;
        t.idx   = idx;
        t.data  = data;
        t.typed = typed;
        t.want  = want;
        directed_rows.push_back(t);
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic offer(input t_timer_txn t);
        if (!calm && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= t.func;
        i_timer_index <= t.idx;
        i_write_data  <= t.data;
        offer_typed   <= t.typed;
        offer_want    <= t.want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drain the bank, then write both FIFO selects
    task automatic write_fifo_sel(input logic sel_a, input logic sel_b);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expect_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIFO_A_SEL;
        i_cfg_data  <= sel_a;
        @(posedge i_clk);
        i_cfg_index <= CFG_FIFO_B_SEL;
        i_cfg_data  <= sel_b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fifo_a_sel   = sel_a;
        fifo_b_sel   = sel_b;
    endtask

    // Receiver: random stalls, one long hold-off, a calm stretch
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // Checker: retire the result first, then queue the new expectation
    always @(posedge i_clk) begin : check_proc
        t_timer_result got;
        t_timer_result want;
        if (o_valid && i_ready) begin
            got = {o_read_data, o_overflow_flags, o_irq_flags,
                   o_fifo_a_request, o_fifo_b_request};
            if (expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result at %0t: read_data %h overflow %h irq %h",
                             $time, got.read_data, got.ovf, got.irq);
                end
            end else begin
                want = expect_q.pop_front();
                if (got.read_data != want.read_data || got.ovf != want.ovf
                        || got.irq != want.irq || got.fifo_a != want.fifo_a
                        || got.fifo_b != want.fifo_b) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at %0t (expected/actual): read_data %h/%h",
                                 $time, want.read_data, got.read_data);
                        $display("  overflow %h/%h irq %h/%h fifo_a %b/%b fifo_b %b/%b",
                                 want.ovf, got.ovf, want.irq, got.irq,
                                 want.fifo_a, got.fifo_a, want.fifo_b, got.fifo_b);
                    end
                end
            end
        end
        if (i_valid && o_ready) begin
            want = step_timer_bank(i_func, i_timer_index, i_write_data);
            if (offer_typed) begin
                want = offer_want;
            end
            expect_q.push_back(want);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stim_proc
        t_timer_txn t;
        int         pick;
        int         shape;
        logic [3:0] sel_a_plan;
        logic [3:0] sel_b_plan;
        sel_a_plan = 4'b0101;
        sel_b_plan = 4'b0110;

        // read and tick straight after reset
        add_row(FUNC_RD_COUNT,  2'd0, 16'hFFFF, 1'b1, '0);
        add_row(FUNC_TICK,      2'd3, 16'hFFFF, 1'b1, '0);
        // timer 0 at the top of its range, divide by one, interrupt on
        add_row(FUNC_WR_RELOAD, 2'd0, 16'hFFFF, 1'b1, '0);
        add_row(FUNC_WR_CTRL,   2'd0, 16'h00C0, 1'b1, '0);
        add_row(FUNC_RD_COUNT,  2'd0, 16'h0000, 1'b1, {16'hFFFF, 4'h0, 4'h0, 1'b0, 1'b0});
        add_row(FUNC_TICK,      2'd0, 16'h0000, 1'b1, {16'h0000, 4'h1, 4'h1, 1'b1, 1'b1});
        // timer 1 cascaded from timer 0
        add_row(FUNC_WR_RELOAD, 2'd1, 16'hFFFE, 1'b1, '0);
        add_row(FUNC_WR_CTRL,   2'd1, 16'h0084, 1'b1, '0);
        add_row(FUNC_TICK,      2'd1, 16'h5555, 1'b0, '0);
        add_row(FUNC_TICK,      2'd2, 16'hAAAA, 1'b0, '0);
        // run bit already set: no reload, upper byte dropped
        add_row(FUNC_WR_CTRL,   2'd0, 16'hFFC0, 1'b1, '0);
        add_row(FUNC_RD_COUNT,  2'd1, 16'h0000, 1'b0, '0);
        // reload write leaves the live count alone
        add_row(FUNC_WR_RELOAD, 2'd2, 16'h1234, 1'b1, '0);
        add_row(FUNC_RD_COUNT,  2'd2, 16'h0000, 1'b1, '0);
        add_row(FUNC_WR_CTRL,   2'd2, 16'h00C3, 1'b1, '0);
        add_row(FUNC_RD_COUNT,  2'd2, 16'h0000, 1'b1, {16'h1234, 4'h0, 4'h0, 1'b0, 1'b0});
        // timer 3 with every control bit set
        add_row(FUNC_WR_RELOAD, 2'd3, 16'h0000, 1'b1, '0);
        add_row(FUNC_WR_CTRL,   2'd3, 16'h00FF, 1'b1, '0);
        add_row(FUNC_TICK,      2'd0, 16'h0000, 1'b0, '0);
        // stop and restart timer 1
        add_row(FUNC_WR_CTRL,   2'd1, 16'h0000, 1'b1, '0);
        add_row(FUNC_TICK,      2'd0, 16'h0000, 1'b0, '0);
        add_row(FUNC_WR_CTRL,   2'd1, 16'h0084, 1'b1, '0);
        add_row(FUNC_RD_COUNT,  2'd3, 16'h0000, 1'b0, '0);
        add_row(FUNC_TICK,      2'd0, 16'h0000, 1'b0, '0);
        add_row(FUNC_RD_COUNT,  2'd1, 16'hFFFF, 1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_fifo_sel(1'b0, 1'b0);
        foreach (directed_rows[k]) begin
            offer(directed_rows[k]);
        end

        for (int p = 0; p < 4; p++) begin
            write_fifo_sel(sel_a_plan[p], sel_b_plan[p]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // long stretch without gaps, opened by a receiver hold-off
                if (p == 0 && n == 40) begin
                    calm     <= 1'b1;
                    hold_req <= 1'b1;
                end else if (p == 0 && n == 200) begin
                    calm <= 1'b0;
                end
                pick   = $urandom_range(99);
                t      = '0;
                t.idx  = 2'($urandom_range(3));
                t.data = 16'($urandom_range(16'hFFFF));
                if (pick < 50) begin
                    t.func = FUNC_TICK;
                end else if (pick < 62) begin
                    t.func = FUNC_WR_RELOAD;
                    // keep most reloads near the top so overflows come often
                    shape = $urandom_range(9);
                    if (shape < 6) begin
                        t.data = 16'hFFFF - 16'($urandom_range(15));
                    end else if (shape < 8) begin
                        t.data[15:8] = 8'hFF;
                    end
                end else if (pick < 77) begin
                    t.func = FUNC_WR_CTRL;
                    t.data[CTL_RUN_BIT] = ($urandom_range(3) != 0);
                    if ($urandom_range(9) < 6) begin
                        t.data[1:0] = 2'd0;
                    end
                end else begin
                    t.func = FUNC_RD_COUNT;
                end
                offer(t);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- cascaded_prescaled_timers.f -----
design/cpt_pkg.sv
design/cpt_cell.sv
design/cascaded_prescaled_timers.sv
tb/tb_cascaded_prescaled_timers.sv
